/* rtl/vau_pkg.sv */
// package: opcodes, status codes, controller states and the command struct
package vau_pkg;
  localparam int ElemW  = 16;
  localparam int ValueW = 48;
  localparam int AccW   = 40;
  localparam int SqW    = 20;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0, OP_SUB = 3'd1, OP_DOT = 3'd2,
    OP_CROSS = 3'd3, OP_MAG = 3'd4, OP_NORM = 3'd5
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_MISMATCH = 3'd1, ST_NOT3D = 3'd2,
    ST_ZERO = 3'd3, ST_TOO_LONG = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_LOAD, S_CHECK, S_EMIT_ADD, S_DOT_ACC, S_CROSS, S_SUMSQ,
    S_SQRT, S_MAG_OUT, S_DIV, S_NORM_OUT, S_ERR_OUT, S_WAIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic rd_start;
    logic rd_step;
    logic acc_clear;
    logic acc_dot;
    logic acc_sq;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic [1:0] cross_sel;
    logic cross_mul;
  } cmd_t;
endpackage

/* rtl/vau_if.sv */
// valid/ready stream interfaces for input and result items
interface vau_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic signed [15:0] a_elem;
  logic signed [15:0] b_elem;
  logic        a_present;
  logic        b_present;
  logic        last_in;
  modport source (output valid, opcode, a_elem, b_elem, a_present, b_present, last_in,
                  input ready);
  modport sink (input valid, opcode, a_elem, b_elem, a_present, b_present, last_in,
                output ready);
endinterface

interface vau_out_if;
  logic        valid;
  logic        ready;
  logic signed [47:0] value;
  logic [2:0]  status;
  logic        last_out;
  modport source (output valid, value, status, last_out, input ready);
  modport sink (input valid, value, status, last_out, output ready);
endinterface

/* rtl/vau_ctrl.sv */
// controller: sequences loading, the operation and the result items
module vau_ctrl #(
  parameter int MaxLen = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic in_last,
  input  logic [2:0] opcode,
  input  logic too_long,
  input  logic [$clog2(MaxLen+1)-1:0] a_cnt,
  input  logic [$clog2(MaxLen+1)-1:0] b_cnt,
  input  logic rd_last,
  input  logic sqrt_done,
  input  logic div_done,
  input  logic mag_zero,
  input  logic out_free,
  output logic in_ready,
  output vau_pkg::cmd_t cmd,
  output logic out_load,
  output vau_pkg::status_t out_status,
  output logic [2:0] out_src,
  output logic out_last
);
  import vau_pkg::*;
  localparam int CntW = $clog2(MaxLen+1);

  state_t state, state_next;
  logic [2:0] op;
  logic started;
  status_t err;
  logic [1:0] cidx;
  logic [1:0] cidx_next;
  logic [1:0] phase, phase_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cidx <= '0;
      phase <= '0;
      op <= 3'd0;
      started <= 1'b0;
    end else begin
      state <= state_next;
      cidx <= cidx_next;
      phase <= phase_next;
      // opcode comes from the first item of a run, whatever it carries
      if (state == S_WAIT) started <= 1'b0;
      else if (in_fire && !started) begin
        op <= opcode;
        started <= 1'b1;
      end
    end
  end

  opcode_t eop;
  assign eop = (op > 3'd5) ? OP_ADD : opcode_t'(op);

  always_comb begin
    err = ST_OK;
    if (too_long) err = ST_TOO_LONG;
    else if ((eop == OP_ADD || eop == OP_SUB || eop == OP_DOT) && a_cnt != b_cnt)
      err = ST_MISMATCH;
    else if (eop == OP_CROSS && (a_cnt != CntW'(3) || b_cnt != CntW'(3)))
      err = ST_NOT3D;
  end

  // next state
  always_comb begin
    state_next = state;
    cidx_next = cidx;
    phase_next = phase;
    unique case (state)
      S_LOAD: if (in_fire && in_last) state_next = S_CHECK;
      S_CHECK: begin
        if (err != ST_OK) state_next = S_ERR_OUT;
        // empty vector: a single zero item, zero-magnitude status for normalize
        else if (a_cnt == '0) state_next = S_ERR_OUT;
        else begin
          unique case (eop)
            OP_ADD, OP_SUB: state_next = S_EMIT_ADD;
            OP_DOT: state_next = S_DOT_ACC;
            OP_CROSS: begin state_next = S_CROSS; cidx_next = '0; phase_next = '0; end
            default: state_next = S_SUMSQ;
          endcase
        end
      end
      S_EMIT_ADD: if (out_free && rd_last) state_next = S_WAIT;
      S_DOT_ACC: if (rd_last) state_next = S_MAG_OUT;
      S_CROSS: begin
        if (phase != 2'd2) phase_next = phase + 2'd1;
        else if (out_free) begin
          phase_next = '0;
          cidx_next = cidx + 2'd1;
          if (cidx == 2'd2) state_next = S_WAIT;
        end
      end
      S_SUMSQ: if (rd_last) state_next = S_SQRT;
      S_SQRT: if (sqrt_done) begin
        if (eop == OP_MAG) state_next = S_MAG_OUT;
        else if (mag_zero) state_next = S_ERR_OUT;
        else state_next = S_DIV;
      end
      S_MAG_OUT: if (out_free) state_next = S_WAIT;
      S_DIV: if (div_done) state_next = S_NORM_OUT;
      S_NORM_OUT: if (out_free) state_next = rd_last ? S_WAIT : S_DIV;
      S_ERR_OUT: if (out_free) state_next = S_WAIT;
      S_WAIT: state_next = S_LOAD;
      default: state_next = S_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    in_ready = (state == S_LOAD);
    out_load = 1'b0;
    out_status = ST_OK;
    out_src = 3'd0;
    out_last = 1'b0;
    cmd.cross_sel = cidx;
    unique case (state)
      S_CHECK: begin
        cmd.rd_start = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      S_EMIT_ADD: begin
        out_src = (eop == OP_SUB) ? 3'd1 : 3'd0;
        out_load = out_free;
        out_last = rd_last;
        cmd.rd_step = out_free;
      end
      S_DOT_ACC: begin cmd.acc_dot = 1'b1; cmd.rd_step = 1'b1; end
      S_SUMSQ: begin
        cmd.acc_sq = 1'b1; cmd.rd_step = 1'b1;
        cmd.sqrt_start = rd_last;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cmd.rd_start = 1'b1;
        cmd.div_start = sqrt_done;
      end
      S_CROSS: begin
        cmd.cross_mul = (phase == 2'd1);
        out_src = 3'd2;
        out_load = (phase == 2'd2) && out_free;
        out_last = (cidx == 2'd2);
      end
      S_MAG_OUT: begin
        out_src = (eop == OP_DOT) ? 3'd3 : 3'd4;
        out_load = out_free;
        out_last = 1'b1;
      end
      S_DIV: cmd.div_step = 1'b1;
      S_NORM_OUT: begin
        out_src = 3'd5;
        out_load = out_free;
        out_last = rd_last;
        cmd.rd_step = out_free;
        cmd.div_start = out_free && !rd_last;
      end
      S_ERR_OUT: begin
        out_src = 3'd6;
        out_status = (err == ST_OK && eop == OP_NORM) ? ST_ZERO : err;
        out_load = out_free;
        out_last = 1'b1;
      end
      S_WAIT: cmd.clear = 1'b1;
      default: ;
    endcase
  end
endmodule

/* rtl/vau_dpath.sv */
// datapath: element stores, accumulator, multiplier, square root and divider
module vau_dpath #(
  parameter int MaxLen = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic signed [15:0] a_elem,
  input  logic signed [15:0] b_elem,
  input  logic a_present,
  input  logic b_present,
  input  vau_pkg::cmd_t cmd,
  input  logic [2:0] out_src,
  output logic too_long,
  output logic [$clog2(MaxLen+1)-1:0] a_cnt,
  output logic [$clog2(MaxLen+1)-1:0] b_cnt,
  output logic rd_last,
  output logic sqrt_done,
  output logic div_done,
  output logic mag_zero,
  output logic signed [47:0] res_value
);
  import vau_pkg::*;
  localparam int CntW = $clog2(MaxLen+1);
  localparam int IdxW = (MaxLen > 1) ? $clog2(MaxLen) : 1;

  logic signed [15:0] amem [MaxLen];
  logic signed [15:0] bmem [MaxLen];
  logic signed [15:0] ard, brd;
  logic [CntW-1:0] ridx;
  logic [IdxW-1:0] raddr;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      a_cnt <= '0;
      b_cnt <= '0;
      too_long <= 1'b0;
    end else if (in_fire) begin
      if (a_present) begin
        if (a_cnt < CntW'(MaxLen)) a_cnt <= a_cnt + 1'b1;
        else too_long <= 1'b1;
      end
      if (b_present) begin
        if (b_cnt < CntW'(MaxLen)) b_cnt <= b_cnt + 1'b1;
        else too_long <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && a_present && a_cnt < CntW'(MaxLen)) amem[a_cnt[IdxW-1:0]] <= a_elem;
    if (in_fire && b_present && b_cnt < CntW'(MaxLen)) bmem[b_cnt[IdxW-1:0]] <= b_elem;
  end

  // read index: S_CHECK / sqrt wait prime it, each step moves on
  always_ff @(posedge clk) begin
    if (rst) ridx <= '0;
    else if (cmd.rd_start) ridx <= '0;
    else if (cmd.rd_step) ridx <= ridx + 1'b1;
  end

  // cross uses fixed taps, otherwise the running index (combinational read)
  logic [IdxW-1:0] ca, cb;
  always_comb begin
    raddr = ridx[IdxW-1:0];
    unique case (cmd.cross_sel)
      2'd0: begin ca = IdxW'(1); cb = IdxW'(2); end
      2'd1: begin ca = IdxW'(2); cb = IdxW'(0); end
      default: begin ca = IdxW'(0); cb = IdxW'(1); end
    endcase
  end

  // stores are read combinationally at ridx; small arrays held in flops
  assign ard = amem[raddr];
  assign brd = bmem[raddr];
  assign rd_last = (ridx + 1'b1 == a_cnt);

  logic signed [31:0] p1, p2;
  logic signed [31:0] prod;
  assign prod = cmd.acc_sq ? ard * ard : ard * brd;

  always_ff @(posedge clk) begin
    if (cmd.cross_mul) begin
      p1 <= amem[ca] * bmem[cb];
    end else begin
      p2 <= amem[cb] * bmem[ca];
    end
  end

  logic signed [AccW-1:0] acc;
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) acc <= '0;
    else if (cmd.acc_dot || cmd.acc_sq) acc <= acc + AccW'(prod);
  end

  // restoring square root, two bits of radicand a step
  logic [AccW-1:0] rem_r, x_r;
  logic [SqW+1:0] root;
  logic [4:0] sq_i;
  logic sq_busy;
  logic [SqW+1:0] trial;
  logic [AccW-1:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r[AccW-3:0], x_r[AccW-1 -: 2]};
    trial = {root[SqW-1:0], 2'b01};
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy <= 1'b0;
      sqrt_done <= 1'b0;
    end else begin
      sqrt_done <= 1'b0;
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
        sq_i <= 5'd0;
        rem_r <= '0;
        root <= '0;
        x_r <= acc + AccW'(prod);
      end else if (sq_busy && cmd.sqrt_step) begin
        x_r <= {x_r[AccW-3:0], 2'b00};
        if (rem_sh >= AccW'(trial)) begin
          rem_r <= rem_sh - AccW'(trial);
          root <= {root[SqW:0], 1'b1};
        end else begin
          rem_r <= rem_sh;
          root <= {root[SqW:0], 1'b0};
        end
        sq_i <= sq_i + 5'd1;
        if (sq_i == 5'd19) begin
          sq_busy <= 1'b0;
          sqrt_done <= 1'b1;
        end
      end
    end
  end
  logic [SqW-1:0] mag;
  assign mag = root[SqW-1:0];
  assign mag_zero = (mag == '0);

  // restoring divide of |a|*2^14 by mag, one quotient bit a step
  localparam int NumW = 30;
  logic [NumW-1:0] num, quo;
  logic [SqW:0] drem;
  logic [4:0] dv_i;
  logic dv_busy, neg;
  logic [SqW:0] dsh;
  assign dsh = {drem[SqW-1:0], num[NumW-1]};
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (cmd.div_start) begin
        dv_busy <= 1'b0;
        dv_i <= '0;
      end else if (cmd.div_step && !dv_busy && dv_i == 5'd0) begin
        dv_busy <= 1'b1;
        neg <= ard[15];
        num <= NumW'({ard[15] ? 16'(-ard) : 16'(ard), 14'd0});
        drem <= '0;
        quo <= '0;
      end else if (dv_busy) begin
        num <= {num[NumW-2:0], 1'b0};
        if (dsh >= {1'b0, mag}) begin
          drem <= dsh - {1'b0, mag};
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          drem <= dsh;
          quo <= {quo[NumW-2:0], 1'b0};
        end
        dv_i <= dv_i + 5'd1;
        if (dv_i == 5'(NumW-1)) begin
          dv_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    unique case (out_src)
      3'd0: res_value = 48'(ard) + 48'(brd);
      3'd1: res_value = 48'(ard) - 48'(brd);
      3'd2: res_value = 48'(p1) - 48'(p2);
      3'd3: res_value = 48'(acc);
      3'd4: res_value = 48'(mag);
      3'd5: res_value = neg ? -48'(quo) : 48'(quo);
      default: res_value = '0;
    endcase
  end
endmodule

/* rtl/vector_arith_unit.sv */
// top level: fixed-point vector arithmetic unit
// Items arrive on the in channel, one element pair per item (a_present and
// b_present mark which elements it carries); the opcode of the first item
// holds for the run and last_in ends it. Results leave on the out channel,
// last_out set on the final result of a run; errors give one status result.
// After the last item the controller runs the operation: add/sub pass a
// check state and then emit one result a cycle while the receiver takes
// them, dot accumulates the products into one result, cross gives its three
// results one by one, magnitude goes through the bit-serial square root (two
// radicand bits a cycle), and normalize divides each element by the
// magnitude in the bit-serial divider. in.ready is low from the last item
// until the wait state that follows the run's final result has passed.
// A single output register holds each result; when the receiver stalls the
// controller waits for it and the stores hold their contents.
// Reset (rst, synchronous) returns the controller to loading with empty
// counts; the element stores are not cleared.
module vector_arith_unit #(
  parameter int MAX_LEN = 16
) (
  input logic clk,
  input logic rst,
  vau_in_if.sink in,
  vau_out_if.source out
);
  import vau_pkg::*;
  localparam int CntW = $clog2(MAX_LEN+1);

  cmd_t cmd;
  logic in_fire, too_long, rd_last, sqrt_done, div_done, mag_zero;
  logic [CntW-1:0] a_cnt, b_cnt;
  logic out_load, out_last_c, out_free;
  status_t out_status_c;
  logic [2:0] out_src;
  logic signed [47:0] res_value;

  assign in_fire = in.valid && in.ready;
  assign out_free = !out.valid || out.ready;

  vau_ctrl #(.MaxLen(MAX_LEN)) u_ctrl (
    .clk, .rst, .in_fire, .in_last(in.last_in), .opcode(in.opcode),
    .too_long, .a_cnt, .b_cnt, .rd_last, .sqrt_done, .div_done, .mag_zero,
    .out_free, .in_ready(in.ready), .cmd, .out_load, .out_status(out_status_c),
    .out_src, .out_last(out_last_c)
  );

  vau_dpath #(.MaxLen(MAX_LEN)) u_dpath (
    .clk, .rst, .in_fire, .a_elem(in.a_elem), .b_elem(in.b_elem),
    .a_present(in.a_present), .b_present(in.b_present), .cmd, .out_src,
    .too_long, .a_cnt, .b_cnt, .rd_last, .sqrt_done, .div_done, .mag_zero,
    .res_value
  );

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (out_load) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out.value <= res_value;
      out.status <= out_status_c;
      out.last_out <= out_last_c;
    end
  end
endmodule
